@@ sv/ccsd_pkg.sv @@
package ccsd_pkg;

  // Request codes
  localparam logic ReqTick = 1'b0;
  localparam logic ReqLoad = 1'b1;

  // Year bounds and reset position
  localparam logic [24:0] YearLastSec  = 25'd31535999;
  localparam logic [24:0] ResetSeconds = 25'd24552324;
  localparam logic [5:0]  AsciiZero    = 6'h30;

  // Time unit sizes
  localparam logic [16:0] SecsPerDay  = 17'd86400;
  localparam logic [11:0] SecsPerHour = 12'd3600;
  localparam logic [5:0]  SecsPerMin  = 6'd60;

  // Reciprocals for constant division:
  //   day    = ((s >> 7) * DayRecip) >> 28     (86400 = 128 * 675)
  //   hour   = ((r >> 4) * HourRecip) >> 20    (3600 = 16 * 225)
  //   minute = ((r >> 2) * MinRecip) >> 14     (60 = 4 * 15)
  localparam logic [18:0] DayRecip  = 19'd397683;
  localparam logic [12:0] HourRecip = 13'd4661;
  localparam logic [10:0] MinRecip  = 11'd1093;

  localparam int unsigned NumMonths = 12;

  // First day index of each month in a 365-day year
  localparam logic [8:0] MonthFirstDay [NumMonths] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // Three ASCII letters per month, first letter in the top byte
  localparam logic [23:0] MonthLetters [NumMonths] = '{
    24'h4A414E, 24'h464542, 24'h4D4152, 24'h415052,
    24'h4D4159, 24'h4A554E, 24'h4A554C, 24'h415547,
    24'h534550, 24'h4F4354, 24'h4E4F56, 24'h444543
  };

  typedef struct packed {
    logic        req_type;
    logic [24:0] load_seconds;
  } in_t;

  typedef struct packed {
    logic [3:0]  month_number;
    logic [23:0] month_name;
    logic [5:0]  day_tens;
    logic [5:0]  day_ones;
    logic [5:0]  hour_tens;
    logic [5:0]  hour_ones;
    logic [5:0]  minute_tens;
    logic [5:0]  minute_ones;
    logic [5:0]  second_tens;
    logic [5:0]  second_ones;
  } out_t;

  typedef struct packed {
    logic [5:0] tens;
    logic [5:0] ones;
  } digits_t;

  // Split a value below 64 into two ASCII digits; tens by multiply-shift
  function automatic digits_t to_digits(input logic [5:0] v);
    logic [13:0] prod;
    logic [2:0]  tens;
    logic [5:0]  ones;
    digits_t     d;
    prod   = 14'(v) * 14'd205;
    tens   = prod[13:11];
    ones   = v - 6'(tens) * 6'd10;
    d.tens = AsciiZero + 6'(tens);
    d.ones = AsciiZero + 6'(ones[3:0]);
    return d;
  endfunction

endpackage

@@ sv/ccsd_decode.sv @@
module ccsd_decode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [24:0]      sec_i,
  output logic             valid_o,
  output ccsd_pkg::out_t   res_o
);

  localparam int unsigned NumStages = 7;

  logic [NumStages-1:0] vld_q, vld_d;

  // Stage registers
  logic [24:0] a_sec_q;
  logic [24:0] b_sec_q;
  logic [8:0]  b_day_q;
  logic [16:0] c_rem_q;
  logic [3:0]  c_mon_q, d_mon_q, e_mon_q, f_mon_q;
  logic [4:0]  c_dom_q, d_dom_q, e_dom_q, f_dom_q;
  logic [16:0] d_rem_q;
  logic [4:0]  d_hour_q, e_hour_q, f_hour_q;
  logic [11:0] e_mrem_q, f_mrem_q;
  logic [5:0]  f_min_q;
  ccsd_pkg::out_t res_q, res_d;

  logic [36:0] day_prod;
  logic [24:0] rem_full;
  logic [3:0]  mon_idx;
  logic [8:0]  dom_full;
  logic [25:0] hour_prod;
  logic [16:0] mrem_full;
  logic [20:0] min_prod;
  logic [11:0] sec_full;
  ccsd_pkg::digits_t dd, hd, md, sd;

  // Day index of the year
  assign day_prod = 37'(a_sec_q[24:7]) * 37'(ccsd_pkg::DayRecip);

  // Second within the day, month and day of month
  assign rem_full = b_sec_q - 25'(b_day_q) * 25'(ccsd_pkg::SecsPerDay);

  always_comb begin
    mon_idx = '0;
    for (int i = 1; i < ccsd_pkg::NumMonths; i++) begin
      if (b_day_q >= ccsd_pkg::MonthFirstDay[i]) begin
        mon_idx = 4'(i);
      end
    end
  end

  assign dom_full = b_day_q - ccsd_pkg::MonthFirstDay[mon_idx] + 9'd1;

  // Hour of the day
  assign hour_prod = 26'(c_rem_q[16:4]) * 26'(ccsd_pkg::HourRecip);

  // Second within the hour
  assign mrem_full = d_rem_q - 17'(d_hour_q) * 17'(ccsd_pkg::SecsPerHour);

  // Minute of the hour
  assign min_prod = 21'(e_mrem_q[11:2]) * 21'(ccsd_pkg::MinRecip);

  // Second of the minute and ASCII digits
  assign sec_full = f_mrem_q - 12'(f_min_q) * 12'(ccsd_pkg::SecsPerMin);

  assign dd = ccsd_pkg::to_digits(6'(f_dom_q));
  assign hd = ccsd_pkg::to_digits(6'(f_hour_q));
  assign md = ccsd_pkg::to_digits(f_min_q);
  assign sd = ccsd_pkg::to_digits(sec_full[5:0]);

  always_comb begin
    res_d.month_number = f_mon_q + 4'd1;
    res_d.month_name   = ccsd_pkg::MonthLetters[f_mon_q];
    res_d.day_tens     = dd.tens;
    res_d.day_ones     = dd.ones;
    res_d.hour_tens    = hd.tens;
    res_d.hour_ones    = hd.ones;
    res_d.minute_tens  = md.tens;
    res_d.minute_ones  = md.ones;
    res_d.second_tens  = sd.tens;
    res_d.second_ones  = sd.ones;
  end

  // Advance valid flags with the pipeline
  assign vld_d = {vld_q[NumStages-2:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld_d;
    end
  end

  // Advance payload; hold while the output stalls
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_sec_q  <= sec_i;
      b_sec_q  <= a_sec_q;
      b_day_q  <= day_prod[36:28];
      c_rem_q  <= rem_full[16:0];
      c_mon_q  <= mon_idx;
      c_dom_q  <= dom_full[4:0];
      d_rem_q  <= c_rem_q;
      d_hour_q <= hour_prod[24:20];
      d_mon_q  <= c_mon_q;
      d_dom_q  <= c_dom_q;
      e_mrem_q <= mrem_full[11:0];
      e_hour_q <= d_hour_q;
      e_mon_q  <= d_mon_q;
      e_dom_q  <= d_dom_q;
      f_mrem_q <= e_mrem_q;
      f_min_q  <= min_prod[19:14];
      f_hour_q <= e_hour_q;
      f_mon_q  <= e_mon_q;
      f_dom_q  <= e_dom_q;
      res_q    <= res_d;
    end
  end

  assign valid_o = vld_q[NumStages-1];
  assign res_o   = res_q;

endmodule

@@ sv/calendar_clock_seconds_decoder.sv @@
// Seconds-of-year calendar clock. Each input transfer either ticks the
// counter by one second (wrapping from the last second of the year to 0)
// or loads it (values past the year clamp to its last second); every
// transfer yields one result with month number, month name and ASCII
// digits for day, hour, minute and second of a 365-day year. The result
// shows at the output from the last of seven register stages of
// constant-reciprocal multiplies, and one item is taken per cycle while
// the pipeline moves. The whole pipeline holds while a result waits at
// the output and out_ready_i is low, and in_ready_o is low only then.
module calendar_clock_seconds_decoder (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ccsd_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ccsd_pkg::out_t   out_data_o
);

  logic        en;
  logic        in_xfer;
  logic [24:0] sec_q, sec_d;

  // Move the pipeline unless a result waits at the output
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;
  assign in_xfer    = in_valid_i && en;

  // Next count: load with clamp, or tick with wrap
  always_comb begin
    if (in_data_i.req_type == ccsd_pkg::ReqLoad) begin
      sec_d = (in_data_i.load_seconds > ccsd_pkg::YearLastSec) ?
              ccsd_pkg::YearLastSec : in_data_i.load_seconds;
    end else begin
      sec_d = (sec_q >= ccsd_pkg::YearLastSec) ? '0 : sec_q + 25'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q <= ccsd_pkg::ResetSeconds;
    end else if (in_xfer) begin
      sec_q <= sec_d;
    end
  end

  ccsd_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_xfer),
    .sec_i   (sec_d),
    .valid_o (out_valid_o),
    .res_o   (out_data_o)
  );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam logic [24:0] LAST_SECOND   = 25'd31535999;
  localparam logic [24:0] START_SECONDS = 25'd24552324;
  localparam int unsigned DAY_SECONDS   = 86400;
  localparam int unsigned RANDOM_ITEMS  = 1300;
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  typedef struct {
    ccsd_pkg::in_t  item;
    bit             known;
    ccsd_pkg::out_t want;
  } date_row_t;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  ccsd_pkg::in_t  in_data_i   = '0;
  logic           out_ready_i = 1'b0;
  logic           in_ready_o;
  logic           out_valid_o;
  ccsd_pkg::out_t out_data_o;

  ccsd_pkg::out_t pending_dates[$];
  date_row_t      dir_rows[$];
  logic [24:0]    model_seconds;
  int unsigned    error_count  = 0;
  int unsigned    result_index = 0;
  int unsigned    cycle_count  = 0;
  bit             quiet        = 1'b0;

  calendar_clock_seconds_decoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  // First day index of a month, counted from zero
  function automatic int unsigned month_start(int unsigned m);
    case (m)
      0:  return 0;
      1:  return 31;
      2:  return 59;
      3:  return 90;
      4:  return 120;
      5:  return 151;
      6:  return 181;
      7:  return 212;
      8:  return 243;
      9:  return 273;
      10: return 304;
      default: return 334;
    endcase
  endfunction

  function automatic logic [23:0] month_label(int unsigned m);
    case (m)
      0:  return "JAN";
      1:  return "FEB";
      2:  return "MAR";
      3:  return "APR";
      4:  return "MAY";
      5:  return "JUN";
      6:  return "JUL";
      7:  return "AUG";
      8:  return "SEP";
      9:  return "OCT";
      10: return "NOV";
      default: return "DEC";
    endcase
  endfunction

  // Build a result from decimal calendar values
  function automatic ccsd_pkg::out_t calendar_fields(int unsigned mon, logic [23:0] label,
                                                     int unsigned day, int unsigned hr,
                                                     int unsigned mi, int unsigned se);
    ccsd_pkg::out_t r;
    r.month_number = 4'(mon);
    r.month_name   = label;
    r.day_tens     = 6'(48 + day / 10);
    r.day_ones     = 6'(48 + day % 10);
    r.hour_tens    = 6'(48 + hr / 10);
    r.hour_ones    = 6'(48 + hr % 10);
    r.minute_tens  = 6'(48 + mi / 10);
    r.minute_ones  = 6'(48 + mi % 10);
    r.second_tens  = 6'(48 + se / 10);
    r.second_ones  = 6'(48 + se % 10);
    return r;
  endfunction

  // Tick wraps at the end of the year; loads clamp to its last second
  function automatic logic [24:0] next_count(logic [24:0] cur, ccsd_pkg::in_t item);
    if (item.req_type == ccsd_pkg::ReqLoad) begin
      return (item.load_seconds > LAST_SECOND) ? LAST_SECOND : item.load_seconds;
    end
    return (cur >= LAST_SECOND) ? 25'd0 : cur + 25'd1;
  endfunction

  function automatic ccsd_pkg::out_t decode_date(logic [24:0] count);
    int unsigned s, day_idx, rem, m;
    s       = count;
    day_idx = s / DAY_SECONDS;
    rem     = s % DAY_SECONDS;
    m       = 11;
    while (m > 0 && day_idx < month_start(m)) m--;
    return calendar_fields(m + 1, month_label(m), day_idx - month_start(m) + 1,
                           rem / 3600, (rem % 3600) / 60, rem % 60);
  endfunction

  // Mostly short gaps, a few long ones, none in quiet phases
  function automatic int unsigned idle_cycles();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Ticks dominate; loads aim mostly just short of a rollover
  function automatic ccsd_pkg::in_t random_item();
    ccsd_pkg::in_t it;
    int unsigned   r, day, hr, mi;
    r = $urandom_range(0, 99);
    it.load_seconds = 25'($urandom);
    it.req_type     = ccsd_pkg::ReqTick;
    if (r < 65) return it;
    it.req_type = ccsd_pkg::ReqLoad;
    if (r < 75) return it;
    if (r < 80) begin
      it.load_seconds = 25'($urandom_range(31535990, 33554431));
      return it;
    end
    if ($urandom_range(0, 1)) day = month_start($urandom_range(1, 11)) - 1;
    else day = $urandom_range(0, 364);
    hr = $urandom_range(0, 1) ? 23 : $urandom_range(0, 23);
    mi = $urandom_range(0, 1) ? 59 : $urandom_range(0, 59);
    it.load_seconds = 25'(day * DAY_SECONDS + hr * 3600 + mi * 60
                          + $urandom_range(50, 59));
    return it;
  endfunction

  task automatic flag_mismatch(string field, int unsigned got, int unsigned want);
    $display("result %0d: %s got 0x%0h, want 0x%0h", result_index, field, got, want);
    error_count++;
  endtask

  task automatic check_date(ccsd_pkg::out_t got, ccsd_pkg::out_t want);
    if (got.month_number !== want.month_number)
      flag_mismatch("month_number", got.month_number, want.month_number);
    if (got.month_name !== want.month_name)
      flag_mismatch("month_name", got.month_name, want.month_name);
    if (got.day_tens !== want.day_tens)
      flag_mismatch("day_tens", got.day_tens, want.day_tens);
    if (got.day_ones !== want.day_ones)
      flag_mismatch("day_ones", got.day_ones, want.day_ones);
    if (got.hour_tens !== want.hour_tens)
      flag_mismatch("hour_tens", got.hour_tens, want.hour_tens);
    if (got.hour_ones !== want.hour_ones)
      flag_mismatch("hour_ones", got.hour_ones, want.hour_ones);
    if (got.minute_tens !== want.minute_tens)
      flag_mismatch("minute_tens", got.minute_tens, want.minute_tens);
    if (got.minute_ones !== want.minute_ones)
      flag_mismatch("minute_ones", got.minute_ones, want.minute_ones);
    if (got.second_tens !== want.second_tens)
      flag_mismatch("second_tens", got.second_tens, want.second_tens);
    if (got.second_ones !== want.second_ones)
      flag_mismatch("second_ones", got.second_ones, want.second_ones);
  endtask

  // Drive one transfer at the falling edge and hold it until taken
  task automatic send_item(ccsd_pkg::in_t item, bit known, ccsd_pkg::out_t want);
    int unsigned gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    model_seconds = next_count(model_seconds, item);
    pending_dates.push_back(known ? want : decode_date(model_seconds));
    @(negedge clk_i);
  endtask

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Compare each result transfer with the oldest expected date
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (pending_dates.size() == 0) begin
        $display("result %0d: no date expected", result_index);
        error_count++;
      end else begin
        check_date(out_data_o, pending_dates.pop_front());
      end
      result_index++;
    end
  end

  // Stall the result side at random
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        stall_left = idle_cycles();
      end
    end
  end

  initial begin
    int unsigned    m;
    ccsd_pkg::out_t blank;
    blank         = '0;
    model_seconds = START_SECONDS;

    // Directed rows: reset position, wrap, clamp, rollovers, month starts
    dir_rows.push_back('{'{ccsd_pkg::ReqTick, 25'd0}, 1'b1,
                         calendar_fields(10, "OCT", 12, 4, 5, 25)});
    dir_rows.push_back('{'{ccsd_pkg::ReqLoad, 25'd0}, 1'b1,
                         calendar_fields(1, "JAN", 1, 0, 0, 0)});
    dir_rows.push_back('{'{ccsd_pkg::ReqTick, 25'h1FFFFFF}, 1'b1,
                         calendar_fields(1, "JAN", 1, 0, 0, 1)});
    dir_rows.push_back('{'{ccsd_pkg::ReqLoad, LAST_SECOND}, 1'b1,
                         calendar_fields(12, "DEC", 31, 23, 59, 59)});
    dir_rows.push_back('{'{ccsd_pkg::ReqTick, 25'h1FFFFFF}, 1'b1,
                         calendar_fields(1, "JAN", 1, 0, 0, 0)});
    dir_rows.push_back('{'{ccsd_pkg::ReqLoad, 25'h1FFFFFF}, 1'b1,
                         calendar_fields(12, "DEC", 31, 23, 59, 59)});
    dir_rows.push_back('{'{ccsd_pkg::ReqLoad, 25'd31536000}, 1'b1,
                         calendar_fields(12, "DEC", 31, 23, 59, 59)});
    dir_rows.push_back('{'{ccsd_pkg::ReqTick, 25'd0}, 1'b1,
                         calendar_fields(1, "JAN", 1, 0, 0, 0)});
    dir_rows.push_back('{'{ccsd_pkg::ReqLoad, 25'd3599}, 1'b0, blank});
    dir_rows.push_back('{'{ccsd_pkg::ReqTick, 25'd0}, 1'b0, blank});
    dir_rows.push_back('{'{ccsd_pkg::ReqLoad, 25'd5097599}, 1'b0, blank});
    dir_rows.push_back('{'{ccsd_pkg::ReqTick, 25'd0}, 1'b0, blank});
    for (m = 1; m < 12; m++)
      dir_rows.push_back('{'{ccsd_pkg::ReqLoad, 25'(month_start(m) * DAY_SECONDS)},
                           1'b0, blank});
    dir_rows.push_back('{'{ccsd_pkg::ReqLoad, 25'h0AAAAAA}, 1'b0, blank});
    dir_rows.push_back('{'{ccsd_pkg::ReqLoad, 25'h1555555}, 1'b0, blank});

    // Hold reset, release on a falling edge
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].known, dir_rows[i].want);

    // Random part in phases; every fourth phase runs without gaps
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) quiet = ((n / 100) % 4 == 3);
      send_item(random_item(), 1'b0, blank);
    end
    quiet      = 1'b0;
    in_valid_i <= 1'b0;

    // Drain outstanding dates, then allow for stray results
    while (pending_dates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0 && pending_dates.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/ccsd_pkg.sv
sv/ccsd_decode.sv
sv/calendar_clock_seconds_decoder.sv
tb/tb_top.sv
